>>> rtl/bcs_pkg.sv
// Shared package for the two-note bell chime synthesizer.
// Holds the configuration record, controller/datapath command and status types,
// register index codes and the sine table arithmetic. It depends on nothing else.
package bcs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONSET       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd6;

    // Harmonic counter width covers up to eight harmonics.
    localparam int HARM_W = 3;
    // Signed accumulators for one note's harmonic sum and for the two-note mix.
    localparam int ACC_W = 34;

    localparam logic [16:0] RAMP_ONE = 17'd65536;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;

    typedef struct packed {
        logic [31:0] first_phase_step;
        logic [31:0] second_phase_step;
        logic [15:0] second_onset;
        logic [15:0] note_length;
        logic [16:0] attack_step;
        logic [31:0] decay_factor;
        logic [14:0] output_gain;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLEAR,
        OP_ADDR,
        OP_ROM,
        OP_HMUL,
        OP_HACC,
        OP_EFF,
        OP_VMUL,
        OP_VACC,
        OP_DEC,
        OP_UPD,
        OP_GAIN,
        OP_CLAMP,
        OP_PCM,
        OP_FINISH,
        OP_SILENT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   note;
        logic   restart;
    } cmd_t;

    typedef struct packed {
        logic act_first;
        logic act_second;
        logic last;
        logic harm_last;
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SEL,
        S_CLEAR,
        S_ADDR,
        S_ROM,
        S_HMUL,
        S_HACC,
        S_EFF,
        S_VMUL,
        S_VACC,
        S_DEC,
        S_UPD,
        S_GAIN,
        S_CLAMP,
        S_PCM,
        S_DONE
    } ctl_state_t;

    // Weights of harmonics one to four in Q1.15; higher harmonics are silent.
    function automatic logic [15:0] harm_weight(input logic [HARM_W-1:0] h);
        logic [15:0] w;
        begin
            case (h)
                3'd0:    w = 16'd32768;
                3'd1:    w = 16'd16384;
                3'd2:    w = 16'd9175;
                3'd3:    w = 16'd3932;
                default: w = 16'd0;
            endcase
            return w;
        end
    endfunction

    // sin(pi/2 * x) for x in Q30 over [0,1], odd polynomial with Q30 coefficients.
    function automatic logic [63:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        begin
            x2 = (x * x) >> 30;
            t  = 64'd5026994 - ((x2 * 64'd172272) >> 30);
            t  = 64'd85569306 - ((x2 * t) >> 30);
            t  = 64'd693598668 - ((x2 * t) >> 30);
            t  = 64'd1686629713 - ((x2 * t) >> 30);
            return (x * t) >> 30;
        end
    endfunction

    // Q1.15 sine of a Q0.32 phase, rounded and clamped to full scale.
    function automatic logic [15:0] sine_from_phase(input logic [31:0] p);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] v;
        begin
            frac = {34'd0, p[29:0]};
            x    = p[30] ? ((64'd1 << 30) - frac) : frac;
            v    = (quarter_sine(x) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            return p[31] ? (16'd0 - v[15:0]) : v[15:0];
        end
    endfunction

endpackage

>>> rtl/bcs_dp.sv
// Datapath of the bell chime synthesizer: note state, sine ROM, shared multiplier.
// Driven by bcs_ctrl through cmd_t and reports status_t; uses bcs_pkg.
module bcs_dp
    import bcs_pkg::*;
#(
    parameter int SINE_ENTRIES   = 1024,
    parameter int HARMONIC_COUNT = 4,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic [SAMPLE_BITS-1:0] res_sample
);

    localparam int IDX_W = $clog2(SINE_ENTRIES);
    localparam int PW    = 33 + IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_ENTRIES - 1);
    localparam logic [31:0] FULL_SCALE = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    function automatic logic [16*SINE_ENTRIES-1:0] build_rom();
        logic [16*SINE_ENTRIES-1:0] rom;
        logic [63:0]                p;
        begin
            rom = '0;
            for (int k = 0; k < SINE_ENTRIES; k++) begin
                p = (64'(k) << 32) / SINE_ENTRIES;
                rom[16*k +: 16] = sine_from_phase(p[31:0]);
            end
            return rom;
        end
    endfunction

    localparam logic [16*SINE_ENTRIES-1:0] SINE_ROM = build_rom();

    // Note state, one slot per note.
    logic [31:0]       phase_reg [2];
    logic [31:0]       env_reg   [2];
    logic [16:0]       ramp_reg  [2];
    logic [16:0]       index_reg;
    logic [HARM_W-1:0] harm_reg;

    // Working registers.
    logic [31:0]              hp_reg;
    logic [IDX_W-1:0]         addr_reg;
    logic [15:0]              rom_reg;
    logic [63:0]              prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  mix_reg;
    logic [30:0]              scaled_reg;

    logic [15:0]       len;
    logic [16:0]       total;
    logic [31:0]       cur_phase;
    logic [31:0]       cur_env;
    logic [16:0]       cur_ramp;
    logic [31:0]       cur_step;
    logic [PW-1:0]     idx_prod;
    logic [IDX_W:0]    idx_wide;
    logic [IDX_W-1:0]  addr_next;
    logic [15:0]       rom_mag;
    logic [ACC_W-1:0]  acc_mag;
    logic [ACC_W-1:0]  mix_mag;
    logic [17:0]       ramp_sum;
    logic [16:0]       ramp_new;
    logic [48:0]       gain_shift;
    logic [30:0]       scaled_new;
    logic [SAMPLE_BITS-2:0] pcm;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_prod;

    assign len   = (cfg.note_length == 16'd0) ? 16'd1 : cfg.note_length;
    assign total = {1'b0, cfg.second_onset} + {1'b0, len};

    assign status.act_first  = index_reg < {1'b0, len};
    assign status.act_second = (index_reg >= {1'b0, cfg.second_onset})
                            && ((index_reg - {1'b0, cfg.second_onset}) < {1'b0, len});
    assign status.last       = ({1'b0, index_reg} + 18'd1) >= {1'b0, total};
    assign status.harm_last  = harm_reg == HARM_W'(HARMONIC_COUNT - 1);

    assign cur_phase = phase_reg[cmd.note];
    assign cur_env   = env_reg[cmd.note];
    assign cur_ramp  = ramp_reg[cmd.note];
    assign cur_step  = cmd.note ? cfg.second_phase_step : cfg.first_phase_step;

    // Table index is the top of phase times table size.
    assign idx_prod  = PW'(hp_reg) * PW'(SINE_ENTRIES);
    assign idx_wide  = idx_prod[PW-1:32];
    assign addr_next = (idx_wide >= (IDX_W + 1)'(SINE_ENTRIES)) ? IDX_LAST
                                                               : idx_wide[IDX_W-1:0];

    assign rom_mag  = rom_reg[15] ? (16'd0 - rom_reg) : rom_reg;
    assign acc_mag  = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
    assign mix_mag  = mix_reg[ACC_W-1] ? (ACC_W'(0) - mix_reg) : mix_reg;

    assign ramp_sum = {1'b0, cur_ramp} + {1'b0, cfg.attack_step};
    assign ramp_new = (ramp_sum > {1'b0, RAMP_ONE}) ? RAMP_ONE : ramp_sum[16:0];

    assign gain_shift = prod_reg[63:15];
    assign scaled_new = (gain_shift > 49'(Q30_ONE)) ? Q30_ONE : gain_shift[30:0];

    assign pcm        = prod_reg[30 +: SAMPLE_BITS-1];
    assign res_sample = mix_reg[ACC_W-1] ? (SAMPLE_BITS'(0) - {1'b0, pcm}) : {1'b0, pcm};

    always_comb
    begin
        case (cmd.op)
            OP_HMUL:
            begin
                mul_a = {16'd0, harm_weight(harm_reg)};
                mul_b = {16'd0, rom_mag};
            end
            OP_EFF:
            begin
                mul_a = cur_env;
                mul_b = {15'd0, cur_ramp};
            end
            OP_VMUL:
            begin
                mul_a = acc_mag[31:0];
                mul_b = prod_reg[47:16];
            end
            OP_DEC:
            begin
                mul_a = cur_env;
                mul_b = cfg.decay_factor;
            end
            OP_GAIN:
            begin
                mul_a = mix_mag[31:0];
                mul_b = {17'd0, cfg.output_gain};
            end
            OP_PCM:
            begin
                mul_a = {1'b0, scaled_reg};
                mul_b = FULL_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

    // Note state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 2; n++)
            begin
                phase_reg[n] <= '0;
                env_reg[n]   <= '1;
                ramp_reg[n]  <= '0;
            end
            index_reg <= '0;
            harm_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_ACCEPT:
                begin
                    if (cmd.restart)
                    begin
                        for (int n = 0; n < 2; n++)
                        begin
                            phase_reg[n] <= '0;
                            env_reg[n]   <= '1;
                            ramp_reg[n]  <= '0;
                        end
                        index_reg <= '0;
                    end
                end
                OP_CLEAR:  harm_reg <= '0;
                OP_HACC:   harm_reg <= harm_reg + HARM_W'(1);
                OP_UPD:
                begin
                    phase_reg[cmd.note] <= cur_phase + cur_step;
                    env_reg[cmd.note]   <= prod_reg[63:32];
                    ramp_reg[cmd.note]  <= ramp_new;
                end
                OP_FINISH: index_reg <= index_reg + 17'd1;
                default:   ;
            endcase
        end
    end

    // Working registers and the registered ROM read.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT: mix_reg <= '0;
            OP_CLEAR:
            begin
                hp_reg  <= cur_phase;
                acc_reg <= '0;
            end
            OP_ADDR:
            begin
                addr_reg <= addr_next;
                hp_reg   <= hp_reg + cur_phase;
            end
            OP_ROM:    rom_reg <= SINE_ROM[{addr_reg, 4'b0000} +: 16];
            OP_HMUL, OP_EFF, OP_VMUL, OP_DEC, OP_GAIN, OP_PCM:
                prod_reg <= mul_prod;
            OP_HACC:
            begin
                if (rom_reg[15])
                    acc_reg <= acc_reg - $signed(ACC_W'(prod_reg[31:0]));
                else
                    acc_reg <= acc_reg + $signed(ACC_W'(prod_reg[31:0]));
            end
            OP_VACC:
            begin
                if (acc_reg[ACC_W-1])
                    mix_reg <= mix_reg - $signed(ACC_W'(prod_reg[63:32]));
                else
                    mix_reg <= mix_reg + $signed(ACC_W'(prod_reg[63:32]));
            end
            OP_CLAMP:  scaled_reg <= scaled_new;
            default:   ;
        endcase
    end

    a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_reg[0] <= RAMP_ONE && ramp_reg[1] <= RAMP_ONE)
        else $error("attack ramp above one");

    a_env_decays: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_UPD |=> env_reg[$past(cmd.note)] <= $past(cur_env))
        else $error("envelope grew on update");

    a_harm_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_VMUL |-> acc_mag < ACC_W'(64'h8000_0000))
        else $error("harmonic sum out of range");

endmodule

>>> rtl/bcs_ctrl.sv
// Controller of the bell chime synthesizer: sequences one sample's work.
// Issues cmd_t to bcs_dp and reads its status_t; uses bcs_pkg.
module bcs_ctrl
    import bcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    restart,
    input  logic    out_free,
    input  status_t status,
    output logic    in_stall,
    output cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic       note_reg, note_next;
    logic       sounding_reg, sounding_next;

    always_comb
    begin
        state_next    = state_reg;
        note_next     = note_reg;
        sounding_next = sounding_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = S_SEL;
                    sounding_next = sounding_reg | restart;
                end
            end
            S_SEL:
            begin
                if (!sounding_reg)
                    state_next = S_DONE;
                else if (status.act_first || status.act_second)
                begin
                    state_next = S_CLEAR;
                    note_next  = !status.act_first;
                end
                else
                    state_next = S_GAIN;
            end
            S_CLEAR: state_next = S_ADDR;
            S_ADDR:  state_next = S_ROM;
            S_ROM:   state_next = S_HMUL;
            S_HMUL:  state_next = S_HACC;
            S_HACC:  state_next = status.harm_last ? S_EFF : S_ADDR;
            S_EFF:   state_next = S_VMUL;
            S_VMUL:  state_next = S_VACC;
            S_VACC:  state_next = S_DEC;
            S_DEC:   state_next = S_UPD;
            S_UPD:
            begin
                if (!note_reg && status.act_second)
                begin
                    state_next = S_CLEAR;
                    note_next  = 1'b1;
                end
                else
                    state_next = S_GAIN;
            end
            S_GAIN:  state_next = S_CLAMP;
            S_CLAMP: state_next = S_PCM;
            S_PCM:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (sounding_reg && status.last)
                        sounding_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.note    = note_reg;
        cmd.restart = restart;
        in_stall    = state_reg != S_IDLE;
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
            S_CLEAR: cmd.op = OP_CLEAR;
            S_ADDR:  cmd.op = OP_ADDR;
            S_ROM:   cmd.op = OP_ROM;
            S_HMUL:  cmd.op = OP_HMUL;
            S_HACC:  cmd.op = OP_HACC;
            S_EFF:   cmd.op = OP_EFF;
            S_VMUL:  cmd.op = OP_VMUL;
            S_VACC:  cmd.op = OP_VACC;
            S_DEC:   cmd.op = OP_DEC;
            S_UPD:   cmd.op = OP_UPD;
            S_GAIN:  cmd.op = OP_GAIN;
            S_CLAMP: cmd.op = OP_CLAMP;
            S_PCM:   cmd.op = OP_PCM;
            S_DONE:
            begin
                if (!out_free)
                    cmd.op = OP_NONE;
                else
                    cmd.op = sounding_reg ? OP_FINISH : OP_SILENT;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            note_reg     <= 1'b0;
            sounding_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            note_reg     <= note_next;
            sounding_reg <= sounding_next;
        end
    end

endmodule

>>> rtl/two_note_bell_chime_synth.sv
// Top level of the two-note bell chime synthesizer: configuration registers,
// output register, and the bcs_ctrl / bcs_dp pair. Uses bcs_pkg.
//
// Usage: each item on the input channel (in_valid / in_stall, field restart)
// asks for one PCM sample. restart = 1 starts the chime at sample zero and
// returns that sample; restart = 0 returns the next sample. While no chime is
// sounding the block returns zero with playing and final_sample low.
// Results leave on the output channel (out_valid / out_stall) with fields
// sample, final_sample and playing; final_sample marks the chime's last sample.
// The block works on one item at a time. A silent item skips the note work;
// a sounding item handles each ringing note (none, one or both) in turn, and
// within a note each harmonic passes in turn through the registered sine ROM
// read and the single shared 32x32 multiplier, which every product goes through.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the finished sample is held at its last step until
// the output register is free. Reset loads the default configuration, clears
// the note state and leaves the block idle with no result pending.
// Write configuration through cfg_wr_en / cfg_index / cfg_data only while idle; the block does not enforce this.
module two_note_bell_chime_synth
    import bcs_pkg::*;
#(
    parameter int SINE_ENTRIES   = 1024,
    parameter int HARMONIC_COUNT = 4,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic                   final_sample,
    output logic                   playing
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic    out_free;
    logic    load;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   final_reg;
    logic                   playing_reg;

    // Configuration registers. Writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_phase_step  <= 32'd76354001;
            cfg_reg.second_phase_step <= 32'd114401956;
            cfg_reg.second_onset      <= 16'd5733;
            cfg_reg.note_length       <= 16'd33075;
            cfg_reg.attack_step       <= 17'd248;
            cfg_reg.decay_factor      <= 32'd4294592732;
            cfg_reg.output_gain       <= 15'd7209;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FIRST_STEP:  cfg_reg.first_phase_step  <= cfg_data;
                REG_SECOND_STEP: cfg_reg.second_phase_step <= cfg_data;
                REG_ONSET:       cfg_reg.second_onset      <= cfg_data[15:0];
                REG_LENGTH:      cfg_reg.note_length       <= cfg_data[15:0];
                REG_ATTACK:      cfg_reg.attack_step       <= cfg_data[16:0];
                REG_DECAY:       cfg_reg.decay_factor      <= cfg_data;
                REG_GAIN:        cfg_reg.output_gain       <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    // The result may be written when the output register is empty or is
    // being drained in this same cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (cmd.op == OP_FINISH) || (cmd.op == OP_SILENT);

    bcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .restart  (restart),
        .out_free (out_free),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bcs_dp #(
        .SINE_ENTRIES   (SINE_ENTRIES),
        .HARMONIC_COUNT (HARMONIC_COUNT),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .res_sample (res_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // A silent item returns all zeros.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (cmd.op == OP_FINISH)
            begin
                sample_reg  <= res_sample;
                final_reg   <= status.last;
                playing_reg <= 1'b1;
            end
            else
            begin
                sample_reg  <= '0;
                final_reg   <= 1'b0;
                playing_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign final_sample = final_reg;
    assign playing      = playing_reg;

    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !playing |-> sample == '0 && !final_sample)
        else $error("idle result is not silent");

    a_final_while_playing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_sample |-> playing)
        else $error("final sample flagged while not playing");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new item taken before the previous one finished");

endmodule
